[hw/rtl/art_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// art_pkg
// shared types and constants of the ack retransmit tracker
// ----------------------------------------------------------------------------
package art_pkg;

    localparam int unsigned PendingDepthDefault = 16;
    localparam logic [15:0] FirstTimeoutReset   = 16'd400;
    localparam logic [15:0] RetryIntervalReset  = 16'd100;
    localparam logic [3:0]  MaxAttemptsReset    = 4'd3;

    // command codes
    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_ACK  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    // event codes
    localparam logic [2:0] EV_SENT    = 3'd0;
    localparam logic [2:0] EV_ACKED   = 3'd1;
    localparam logic [2:0] EV_RETX    = 3'd2;
    localparam logic [2:0] EV_TIMEOUT = 3'd3;
    localparam logic [2:0] EV_DONE    = 3'd4;
    localparam logic [2:0] EV_FULL    = 3'd5;

    // register indexes
    localparam logic [1:0] REG_FIRST_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_RETRY         = 2'd1;
    localparam logic [1:0] REG_MAX_ATTEMPTS  = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  robot_id;
        logic [7:0]  cmd_type;
        logic        broadcast;
        logic        fresh_txid;
        logic        needs_ack;
        logic [31:0] ack_txid;
        logic [7:0]  ack_result;
        logic [47:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [31:0] txid;
        logic [7:0]  out_robot;
        logic [7:0]  out_type;
        logic [7:0]  out_result;
        logic [3:0]  attempt;
        logic        last;
    } out_item_t;

    // controller commands to the datapath
    typedef struct packed {
        logic load;       // capture the input transaction
        logic alloc;      // take the transaction id for a send
        logic scan_clr;   // reset the slot pointer and search results
        logic scan_step;  // look at one slot and advance
        logic do_send;    // write or report the send
        logic do_ack;     // free or report the ack
        logic do_tick;    // act on the due slot under the pointer
        logic tick_done;  // report end of tick
    } art_ctrl_t;

    // datapath status to the controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       needs_ack;
        logic       scan_end;
        logic       slot_due;
    } art_stat_t;

endpackage
`default_nettype wire

[hw/rtl/ack_retransmit_tracker_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ack_retransmit_tracker_unit
// table of commands awaiting acknowledgement with timeout and retransmission
// ----------------------------------------------------------------------------
// Usage: present an input transaction on item and raise start while busy is
// low; it is accepted at that edge. Each result appears on res for one cycle
// with res_valid high; the receiver cannot stall. The last result of a
// transaction has last set, and busy falls in the cycle it is on res.
// A send without ack goes from decode straight to its result; a send with
// ack or an ack first makes one search pass over the table, one slot per
// cycle. A tick walks all slots, one per cycle, issuing a retransmit or
// timeout for each due slot, then the done result. The next transaction
// can be accepted at the edge that ends the cycle of the last result.
// Reset clears all table entries, sets the id counter to one and loads the
// register defaults (400, 100, 3). Registers sit on the APB port at 0, 4, 8;
// the user must write them only while busy is low; the block does not enforce it.
// ----------------------------------------------------------------------------
module ack_retransmit_tracker_unit #(
    parameter int unsigned PENDING_DEPTH = art_pkg::PendingDepthDefault
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire art_pkg::in_item_t item,
    output logic                   res_valid,
    output art_pkg::out_item_t     res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    art_pkg::art_ctrl_t ctrl;
    art_pkg::art_stat_t stat;
    logic [15:0] first_timeout_reg, retry_interval_reg;
    logic [3:0]  max_attempts_reg;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_timeout_reg  <= art_pkg::FirstTimeoutReset;
            retry_interval_reg <= art_pkg::RetryIntervalReset;
            max_attempts_reg   <= art_pkg::MaxAttemptsReset;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                art_pkg::REG_FIRST_TIMEOUT: first_timeout_reg  <= pwdata[15:0];
                art_pkg::REG_RETRY:         retry_interval_reg <= pwdata[15:0];
                art_pkg::REG_MAX_ATTEMPTS:  max_attempts_reg   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case (reg_idx)
            art_pkg::REG_FIRST_TIMEOUT: prdata = {16'd0, first_timeout_reg};
            art_pkg::REG_RETRY:         prdata = {16'd0, retry_interval_reg};
            art_pkg::REG_MAX_ATTEMPTS:  prdata = {28'd0, max_attempts_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    art_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    art_datapath #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item),
        .ctrl           (ctrl),
        .stat           (stat),
        .first_timeout  (first_timeout_reg),
        .retry_interval (retry_interval_reg),
        .max_attempts   (max_attempts_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

endmodule
`default_nettype wire

[hw/rtl/art_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// art_ctrl
// sequencer: one transaction at a time, slot scans over cycles
// ----------------------------------------------------------------------------
module art_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire art_pkg::art_stat_t stat,
    output art_pkg::art_ctrl_t     ctrl
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_SCAN, S_SEND, S_ACK, S_TICK, S_TDONE
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ctrl.scan_clr = 1'b1;
                priority if (stat.cmd == art_pkg::CMD_SEND)
                begin
                    ctrl.alloc = 1'b1;
                    state_next = stat.needs_ack ? S_SCAN : S_SEND;
                end
                else if (stat.cmd == art_pkg::CMD_ACK)
                    state_next = S_SCAN;
                else if (stat.cmd == art_pkg::CMD_TICK)
                    state_next = S_TICK;
                else
                    state_next = S_IDLE;
            end
            S_SCAN:
            begin
                ctrl.scan_step = 1'b1;
                if (stat.scan_end)
                    state_next = (stat.cmd == art_pkg::CMD_SEND) ? S_SEND : S_ACK;
            end
            S_SEND:
            begin
                ctrl.do_send = 1'b1;
                state_next   = S_IDLE;
            end
            S_ACK:
            begin
                ctrl.do_ack = 1'b1;
                state_next  = S_IDLE;
            end
            S_TICK:
            begin
                ctrl.scan_step = 1'b1;
                ctrl.do_tick   = stat.slot_due;
                if (stat.scan_end)
                    state_next = S_TDONE;
            end
            S_TDONE:
            begin
                ctrl.tick_done = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

[hw/rtl/art_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// art_datapath
// pending table, id counter, slot search and result register
// ----------------------------------------------------------------------------
module art_datapath #(
    parameter int unsigned PENDING_DEPTH = art_pkg::PendingDepthDefault
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire art_pkg::in_item_t  item,
    input  wire art_pkg::art_ctrl_t ctrl,
    output art_pkg::art_stat_t      stat,
    input  wire logic [15:0]        first_timeout,
    input  wire logic [15:0]        retry_interval,
    input  wire logic [3:0]         max_attempts,
    output logic                    res_valid,
    output art_pkg::out_item_t      res
);

    localparam int unsigned IdxW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    // entry storage: valid bits reset, fields only read while valid
    logic [PENDING_DEPTH-1:0] valid_reg;
    logic [31:0] etxid_reg  [PENDING_DEPTH];
    logic [7:0]  erobot_reg [PENDING_DEPTH];
    logic [7:0]  etype_reg  [PENDING_DEPTH];
    logic        ebc_reg    [PENDING_DEPTH];
    logic [3:0]  eatt_reg   [PENDING_DEPTH];
    logic [47:0] edl_reg    [PENDING_DEPTH];

    art_pkg::in_item_t item_reg;
    logic [31:0] next_id_reg, last_id_reg, id_reg;
    logic [IdxW-1:0] ptr_reg;
    // search results: first key hit, first free, unicast hit, broadcast hit
    logic            hit_ok_reg, free_ok_reg, uc_ok_reg, bc_ok_reg;
    logic [IdxW-1:0] hit_reg, free_reg, uc_reg, bc_reg;

    // slot under the pointer
    logic        cur_valid, cur_due, cur_timeout;
    logic        key_hit, uc_hit, bc_hit;
    logic [3:0]  cur_att;
    logic [IdxW-1:0] wr_slot;
    logic        wr_ok;
    art_pkg::out_item_t res_next;

    assign cur_valid   = valid_reg[ptr_reg];
    assign cur_att     = eatt_reg[ptr_reg];
    assign cur_due     = cur_valid && (item_reg.now_ms >= edl_reg[ptr_reg]);
    assign cur_timeout = (cur_att >= max_attempts);
    assign key_hit = cur_valid && (etxid_reg[ptr_reg] == id_reg)
                     && (ebc_reg[ptr_reg] == item_reg.broadcast)
                     && (!item_reg.broadcast || erobot_reg[ptr_reg] == item_reg.robot_id);
    assign uc_hit  = cur_valid && !ebc_reg[ptr_reg]
                     && (etxid_reg[ptr_reg] == item_reg.ack_txid);
    assign bc_hit  = cur_valid && ebc_reg[ptr_reg]
                     && (etxid_reg[ptr_reg] == item_reg.ack_txid)
                     && (erobot_reg[ptr_reg] == item_reg.robot_id);

    assign wr_ok   = hit_ok_reg || free_ok_reg;
    assign wr_slot = hit_ok_reg ? hit_reg : free_reg;

    assign stat.cmd       = item_reg.cmd;
    assign stat.needs_ack = item_reg.needs_ack;
    assign stat.scan_end  = (ptr_reg == IdxW'(PENDING_DEPTH - 1));
    assign stat.slot_due  = cur_due;

    // input capture, id counter, scan pointer and search
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_id_reg <= 32'd1;
            last_id_reg <= 32'd0;
            id_reg      <= 32'd0;
            ptr_reg     <= '0;
            hit_ok_reg  <= 1'b0;
            free_ok_reg <= 1'b0;
            uc_ok_reg   <= 1'b0;
            bc_ok_reg   <= 1'b0;
            hit_reg     <= '0;
            free_reg    <= '0;
            uc_reg      <= '0;
            bc_reg      <= '0;
        end
        else
        begin
            if (ctrl.alloc)
            begin
                if (item_reg.fresh_txid)
                begin
                    id_reg      <= next_id_reg;
                    last_id_reg <= next_id_reg;
                    next_id_reg <= (next_id_reg == 32'hFFFF_FFFF) ? 32'd1
                                                                  : next_id_reg + 32'd1;
                end
                else
                    id_reg <= last_id_reg;
            end
            if (ctrl.scan_clr)
            begin
                ptr_reg     <= '0;
                hit_ok_reg  <= 1'b0;
                free_ok_reg <= 1'b0;
                uc_ok_reg   <= 1'b0;
                bc_ok_reg   <= 1'b0;
            end
            else if (ctrl.scan_step)
            begin
                ptr_reg <= stat.scan_end ? '0 : ptr_reg + 1'b1;
                if (key_hit && !hit_ok_reg)
                begin
                    hit_ok_reg <= 1'b1;
                    hit_reg    <= ptr_reg;
                end
                if (!cur_valid && !free_ok_reg)
                begin
                    free_ok_reg <= 1'b1;
                    free_reg    <= ptr_reg;
                end
                if (uc_hit && !uc_ok_reg)
                begin
                    uc_ok_reg <= 1'b1;
                    uc_reg    <= ptr_reg;
                end
                if (bc_hit && !bc_ok_reg)
                begin
                    bc_ok_reg <= 1'b1;
                    bc_reg    <= ptr_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            item_reg <= item;
    end

    // table valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (ctrl.do_send && item_reg.needs_ack && wr_ok)
                valid_reg[wr_slot] <= 1'b1;
            if (ctrl.do_ack && uc_ok_reg)
                valid_reg[uc_reg] <= 1'b0;
            else if (ctrl.do_ack && bc_ok_reg)
                valid_reg[bc_reg] <= 1'b0;
            if (ctrl.do_tick && cur_timeout)
                valid_reg[ptr_reg] <= 1'b0;
        end
    end

    // table fields
    always_ff @(posedge clk)
    begin
        if (ctrl.do_send && item_reg.needs_ack && wr_ok)
        begin
            etxid_reg[wr_slot]  <= id_reg;
            erobot_reg[wr_slot] <= item_reg.robot_id;
            etype_reg[wr_slot]  <= item_reg.cmd_type;
            ebc_reg[wr_slot]    <= item_reg.broadcast;
            eatt_reg[wr_slot]   <= 4'd1;
            edl_reg[wr_slot]    <= item_reg.now_ms + {32'd0, first_timeout};
        end
        if (ctrl.do_tick && !cur_timeout)
        begin
            eatt_reg[ptr_reg] <= cur_att + 4'd1;
            edl_reg[ptr_reg]  <= item_reg.now_ms + {32'd0, retry_interval};
        end
    end

    // result fields for the current command
    always_comb
    begin
        res_next = '0;
        if (ctrl.do_send)
        begin
            res_next.event_res = (item_reg.needs_ack && !wr_ok) ? art_pkg::EV_FULL
                                                                : art_pkg::EV_SENT;
            res_next.txid      = id_reg;
            res_next.out_robot = item_reg.robot_id;
            res_next.out_type  = item_reg.cmd_type;
            res_next.last      = 1'b1;
        end
        else if (ctrl.do_ack)
        begin
            res_next.event_res  = (uc_ok_reg || bc_ok_reg) ? art_pkg::EV_ACKED
                                                           : art_pkg::EV_DONE;
            res_next.txid       = item_reg.ack_txid;
            res_next.out_robot  = item_reg.robot_id;
            res_next.out_type   = item_reg.cmd_type;
            res_next.out_result = (uc_ok_reg || bc_ok_reg) ? item_reg.ack_result : 8'd0;
            res_next.last       = 1'b1;
        end
        else if (ctrl.do_tick)
        begin
            res_next.event_res = cur_timeout ? art_pkg::EV_TIMEOUT : art_pkg::EV_RETX;
            res_next.txid      = etxid_reg[ptr_reg];
            res_next.out_robot = erobot_reg[ptr_reg];
            res_next.out_type  = etype_reg[ptr_reg];
            res_next.attempt   = cur_timeout ? cur_att : cur_att + 4'd1;
        end
        else if (ctrl.tick_done)
        begin
            res_next.event_res = art_pkg::EV_DONE;
            res_next.last      = 1'b1;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid <= 1'b0;
        else
            res_valid <= ctrl.do_send | ctrl.do_ack | ctrl.do_tick | ctrl.tick_done;
    end

    always_ff @(posedge clk)
    begin
        res <= res_next;
    end

endmodule
`default_nettype wire

[tb/ack_retransmit_tracker_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ack_retransmit_tracker_checker
// watches accepted transactions and register writes, predicts the events of
// the pending table and compares every issued result field by field
// ----------------------------------------------------------------------------
module ack_retransmit_tracker_checker
    import art_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  in_item_t         item,
    input  wire logic        res_valid,
    input  out_item_t        res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               fail_count,
    output int               pending_events,
    output int               event_count
);

    // predicted table and registers
    logic [15:0] first_to;
    logic [15:0] retry_iv;
    logic [3:0]  max_att;
    logic        tbl_valid [DEPTH];
    logic [31:0] tbl_txid  [DEPTH];
    logic [7:0]  tbl_robot [DEPTH];
    logic [7:0]  tbl_type  [DEPTH];
    logic        tbl_bcast [DEPTH];
    logic [3:0]  tbl_att   [DEPTH];
    logic [47:0] tbl_dl    [DEPTH];
    logic [31:0] next_txid;
    logic [31:0] last_txid;

    out_item_t expected_events[$];

    assign pending_events = expected_events.size();

    function automatic out_item_t make_event(logic [2:0] ev, logic [31:0] id,
                                             logic [7:0] rb, logic [7:0] ty,
                                             logic [7:0] rs, logic [3:0] at,
                                             logic fin);
        out_item_t r;
        r.event_res  = ev;
        r.txid       = id;
        r.out_robot  = rb;
        r.out_type   = ty;
        r.out_result = rs;
        r.attempt    = at;
        r.last       = fin;
        return r;
    endfunction

    // work out the events of one transaction and update the table copy
    task automatic predict_events(input in_item_t it);
        logic [31:0] id;
        int slot;
        slot = -1;
        if (it.cmd == CMD_SEND) begin
            if (it.fresh_txid) begin
                id = next_txid;
                next_txid = (next_txid == 32'hFFFF_FFFF) ? 32'd1 : next_txid + 1;
                last_txid = id;
            end else begin
                id = last_txid;
            end
            if (!it.needs_ack) begin
                expected_events.push_back(make_event(EV_SENT, id, it.robot_id,
                    it.cmd_type, 8'd0, 4'd0, 1'b1));
                return;
            end
            for (int i = 0; i < DEPTH && slot < 0; i++)
                if (tbl_valid[i] && tbl_txid[i] == id && tbl_bcast[i] == it.broadcast
                    && (!it.broadcast || tbl_robot[i] == it.robot_id))
                    slot = i;
            for (int i = 0; i < DEPTH && slot < 0; i++)
                if (!tbl_valid[i])
                    slot = i;
            if (slot < 0) begin
                expected_events.push_back(make_event(EV_FULL, id, it.robot_id,
                    it.cmd_type, 8'd0, 4'd0, 1'b1));
                return;
            end
            tbl_valid[slot] = 1'b1;
            tbl_txid[slot]  = id;
            tbl_robot[slot] = it.robot_id;
            tbl_type[slot]  = it.cmd_type;
            tbl_bcast[slot] = it.broadcast;
            tbl_att[slot]   = 4'd1;
            tbl_dl[slot]    = it.now_ms + 48'(first_to);
            expected_events.push_back(make_event(EV_SENT, id, it.robot_id,
                it.cmd_type, 8'd0, 4'd0, 1'b1));
        end else if (it.cmd == CMD_ACK) begin
            for (int i = 0; i < DEPTH && slot < 0; i++)
                if (tbl_valid[i] && !tbl_bcast[i] && tbl_txid[i] == it.ack_txid)
                    slot = i;
            for (int i = 0; i < DEPTH && slot < 0; i++)
                if (tbl_valid[i] && tbl_bcast[i] && tbl_txid[i] == it.ack_txid
                    && tbl_robot[i] == it.robot_id)
                    slot = i;
            if (slot < 0) begin
                expected_events.push_back(make_event(EV_DONE, it.ack_txid,
                    it.robot_id, it.cmd_type, 8'd0, 4'd0, 1'b1));
            end else begin
                tbl_valid[slot] = 1'b0;
                expected_events.push_back(make_event(EV_ACKED, it.ack_txid,
                    it.robot_id, it.cmd_type, it.ack_result, 4'd0, 1'b1));
            end
        end else if (it.cmd == CMD_TICK) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (!tbl_valid[i] || it.now_ms < tbl_dl[i])
                    continue;
                if (tbl_att[i] >= max_att) begin
                    tbl_valid[i] = 1'b0;
                    expected_events.push_back(make_event(EV_TIMEOUT, tbl_txid[i],
                        tbl_robot[i], tbl_type[i], 8'd0, tbl_att[i], 1'b0));
                end else begin
                    tbl_att[i] = tbl_att[i] + 4'd1;
                    tbl_dl[i]  = it.now_ms + 48'(retry_iv);
                    expected_events.push_back(make_event(EV_RETX, tbl_txid[i],
                        tbl_robot[i], tbl_type[i], 8'd0, tbl_att[i], 1'b0));
                end
            end
            expected_events.push_back(make_event(EV_DONE, 32'd0, 8'd0, 8'd0,
                8'd0, 4'd0, 1'b1));
        end
    endtask

    // compare one issued result with the oldest expectation
    task automatic check_event(input out_item_t got);
        out_item_t exp_ev;
        if (expected_events.size() == 0) begin
            $error("unexpected result: event_res %0d txid %0h", got.event_res, got.txid);
            fail_count++;
            return;
        end
        exp_ev = expected_events.pop_front();
        if (got.event_res !== exp_ev.event_res) begin
            $error("event_res: expected %0d, actual %0d", exp_ev.event_res, got.event_res);
            fail_count++;
        end
        if (got.txid !== exp_ev.txid) begin
            $error("txid: expected %0h, actual %0h", exp_ev.txid, got.txid);
            fail_count++;
        end
        if (got.out_robot !== exp_ev.out_robot) begin
            $error("out_robot: expected %0d, actual %0d", exp_ev.out_robot, got.out_robot);
            fail_count++;
        end
        if (got.out_type !== exp_ev.out_type) begin
            $error("out_type: expected %0d, actual %0d", exp_ev.out_type, got.out_type);
            fail_count++;
        end
        if (got.out_result !== exp_ev.out_result) begin
            $error("out_result: expected %0d, actual %0d", exp_ev.out_result,
                   got.out_result);
            fail_count++;
        end
        if (got.attempt !== exp_ev.attempt) begin
            $error("attempt: expected %0d, actual %0d", exp_ev.attempt, got.attempt);
            fail_count++;
        end
        if (got.last !== exp_ev.last) begin
            $error("last: expected %0d, actual %0d", exp_ev.last, got.last);
            fail_count++;
        end
    endtask

    // sample the channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            first_to    = FirstTimeoutReset;
            retry_iv    = RetryIntervalReset;
            max_att     = MaxAttemptsReset;
            next_txid   = 32'd1;
            last_txid   = 32'd0;
            fail_count  = 0;
            event_count = 0;
            for (int i = 0; i < DEPTH; i++)
                tbl_valid[i] = 1'b0;
            expected_events.delete();
        end else begin
            if (res_valid) begin
                check_event(res);
                event_count++;
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_FIRST_TIMEOUT: first_to = pwdata[15:0];
                    REG_RETRY:         retry_iv = pwdata[15:0];
                    REG_MAX_ATTEMPTS:  max_att  = pwdata[3:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                predict_events(item);
        end
    end

endmodule

[tb/ack_retransmit_tracker_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ack_retransmit_tracker_unit_tb
// drives sends, acks and ticks with random gaps through several register
// settings; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module ack_retransmit_tracker_unit_tb;
    import art_pkg::*;

    localparam int unsigned Depth = 16;
    localparam int MaxCycles = 400000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_item_t    item;
    logic        res_valid;
    out_item_t   res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_events;
    int          event_count;
    int          cycle_count;
    int          txn_count;
    int          reg_errors;
    logic [47:0] clock_ms;
    logic [31:0] ids_seen[$];

    ack_retransmit_tracker_unit #(
        .PENDING_DEPTH(Depth)
    ) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .res_valid(res_valid), .res(res), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    ack_retransmit_tracker_checker #(
        .DEPTH(Depth)
    ) u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .res_valid(res_valid), .res(res), .psel(psel), .penable(penable),
        .pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .pending_events(pending_events),
        .event_count(event_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > MaxCycles)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // random idle cycles, mostly short
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        repeat (n) @(posedge clk);
    endtask

    // one transaction: present it and hold start until accepted
    task automatic issue(input in_item_t it);
        item  <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 1'b0;
        txn_count++;
        @(posedge clk);
        while (busy) @(posedge clk);
        // the checker has seen the acceptance by now
        if (it.cmd == CMD_SEND && it.fresh_txid)
            ids_seen.push_back(u_checker.last_txid);
        if ($urandom_range(0, 2) != 0)
            idle_gap();
    endtask

    function automatic in_item_t blank_item();
        in_item_t it;
        it = '0;
        it.robot_id   = 8'($urandom);
        it.cmd_type   = 8'($urandom);
        it.ack_txid   = $urandom;
        it.ack_result = 8'($urandom);
        return it;
    endfunction

    task automatic send_cmd(input logic [7:0] rb, input logic bc, input logic fr,
                            input logic na);
        in_item_t it;
        it = blank_item();
        it.cmd        = CMD_SEND;
        it.robot_id   = rb;
        it.broadcast  = bc;
        it.fresh_txid = fr;
        it.needs_ack  = na;
        it.now_ms     = clock_ms;
        issue(it);
    endtask

    task automatic ack_cmd(input logic [31:0] id, input logic [7:0] rb);
        in_item_t it;
        it = blank_item();
        it.cmd      = CMD_ACK;
        it.ack_txid = id;
        it.robot_id = rb;
        it.now_ms   = 48'({$urandom, $urandom});
        issue(it);
    endtask

    task automatic tick_cmd(input logic [47:0] advance);
        in_item_t it;
        clock_ms = clock_ms + advance;
        it = blank_item();
        it.cmd    = CMD_TICK;
        it.now_ms = clock_ms;
        issue(it);
    endtask

    // register write: setup then access, then read back
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] exp_rd;
        case (idx)
            REG_FIRST_TIMEOUT: exp_rd = {16'd0, val[15:0]};
            REG_RETRY:         exp_rd = {16'd0, val[15:0]};
            REG_MAX_ATTEMPTS:  exp_rd = {28'd0, val[3:0]};
            default:           exp_rd = 32'd0;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (prdata !== exp_rd)
        begin
            $error("prdata: expected %0h, actual %0h", exp_rd, prdata);
            reg_errors++;
        end
    endtask

    task automatic wait_drain();
        while (pending_events != 0 || busy) @(posedge clk);
        repeat (Depth + 8) @(posedge clk);
    endtask

    task automatic set_regs(input logic [15:0] ft, input logic [15:0] ri,
                            input logic [3:0] ma);
        wait_drain();
        reg_write(REG_FIRST_TIMEOUT, {16'($urandom_range(0, 65535)), ft});
        reg_write(REG_RETRY, {16'hFFFF, ri});
        reg_write(REG_MAX_ATTEMPTS, {28'hFFFFFFF, ma});
    endtask

    // random phase: well formed fan-outs, acks of issued ids, ticks, some noise
    task automatic random_phase(input int n);
        int k;
        logic [31:0] id;
        in_item_t it;
        for (int j = 0; j < n; j++)
        begin
            k = $urandom_range(0, 99);
            if (k < 35)
            begin
                send_cmd(8'($urandom), 1'b0, 1'b1, $urandom_range(0, 5) != 0);
            end
            else if (k < 50)
            begin
                send_cmd(8'($urandom_range(0, 3)), 1'b1, 1'b1, 1'b1);
                repeat ($urandom_range(1, 3))
                    send_cmd(8'($urandom_range(0, 7)), 1'b1, 1'b0, 1'b1);
            end
            else if (k < 70)
            begin
                id = (ids_seen.size() != 0) ?
                     ids_seen[$urandom_range(0, ids_seen.size() - 1)] : $urandom;
                ack_cmd(id, 8'($urandom_range(0, 7)));
            end
            else if (k < 92)
            begin
                tick_cmd($urandom_range(0, 9) < 3 ? 48'($urandom_range(0, 50))
                                                  : 48'($urandom_range(50, 700)));
            end
            else if (k < 96)
            begin
                ack_cmd($urandom, 8'($urandom));
            end
            else
            begin
                it = blank_item();
                it.cmd        = CMD_NOP;
                it.broadcast  = 1'($urandom);
                it.fresh_txid = 1'($urandom);
                it.needs_ack  = 1'($urandom);
                it.now_ms     = 48'({$urandom, $urandom});
                issue(it);
            end
        end
    endtask

    initial
    begin
        start      = 1'b0;
        item       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        rst_n      = 1'b0;
        txn_count  = 0;
        reg_errors = 0;
        clock_ms   = 48'd1000;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reuse before any allocation, extremes, full table, acks
        send_cmd(8'd0, 1'b0, 1'b0, 1'b1);
        send_cmd(8'hFF, 1'b1, 1'b1, 1'b0);
        for (int i = 0; i < Depth + 1; i++)
            send_cmd(8'(i), 1'b1, i == 0, 1'b1);
        send_cmd(8'd3, 1'b1, 1'b0, 1'b1);
        ack_cmd(32'd0, 8'd0);
        ack_cmd(32'd2, 8'd5);
        ack_cmd(32'hFFFF_FFFF, 8'hFF);
        tick_cmd(48'd399);
        tick_cmd(48'd1);
        tick_cmd(48'd100);
        tick_cmd(48'd100);

        // max attempts zero and wrapped deadlines near the top of time
        set_regs(16'hFFFF, 16'hFFFF, 4'd0);
        clock_ms = 48'hFFFF_FFFF_FF00;
        send_cmd(8'hAA, 1'b0, 1'b1, 1'b1);
        tick_cmd(48'd0);
        tick_cmd(48'h0000_0001_0000);
        random_phase(25);

        set_regs(16'd1, 16'd1, 4'd15);
        random_phase(60);
        set_regs(16'd300, 16'd150, 4'd2);
        random_phase(50);
        set_regs(16'd400, 16'd100, 4'd3);
        random_phase(50);

        wait_drain();
        $display("run covered %0d transactions and %0d results over five register settings",
                 txn_count, event_count);
        if (fail_count == 0 && reg_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[ack_retransmit_tracker_unit.f]
hw/rtl/art_pkg.sv
hw/rtl/art_ctrl.sv
hw/rtl/art_datapath.sv
hw/rtl/ack_retransmit_tracker_unit.sv
tb/ack_retransmit_tracker_checker.sv
tb/ack_retransmit_tracker_unit_tb.sv
